// ===== rtl/normalized_walsh_hadamard_transform_macros.svh =====
// Assertion macros shared by the transform RTL.
`ifndef NORMALIZED_WALSH_HADAMARD_TRANSFORM_MACROS_SVH
`define NORMALIZED_WALSH_HADAMARD_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
`define NWHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("property violated");
`define NWHT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("property violated");
`else
`define NWHT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NWHT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/nwht_pkg.sv =====
// Shared types and constants of the normalized Walsh-Hadamard transform.
package nwht_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int MAX_LENGTH_DEF   = 512;
   localparam int BASE_LOG         = 7;
   localparam int LOG_W            = 4;
   localparam int Q_BITS           = 15;
   localparam logic [15:0] INV_SQRT2_Q15 = 16'd23170;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_SIZE_SELECT = 1'b0;
   localparam logic [1:0] SEL_512 = 2'd2;

   // Travels with every item through the cell row.
   typedef struct packed {
      logic pend;
      logic last;
   } cell_tag_type;

   typedef struct packed {
      logic clear;
      logic active;
   } cell_ctrl_type;

endpackage

// ===== rtl/nwht_cell.sv =====
// One butterfly cell with a single-path delay line.
module nwht_cell
   import nwht_pkg::*;
#(
   parameter int STAGE  = 0,
   parameter int IN_W   = 16,
   parameter int LINK_W = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [LINK_W-1:0] in_data,
   input  cell_tag_type             in_tag,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [LINK_W-1:0] out_data,
   output cell_tag_type             out_tag
);

   localparam int DEPTH      = 1 << STAGE;
   localparam int OUT_W      = IN_W + 1;
   localparam int PW         = STAGE + 1;
   localparam int PHASE_INIT = (DEPTH + 1) % (2 * DEPTH);

   logic [PW-1:0]           phase_ff, phase_in;
   logic                    valid_ff, valid_in;
   logic signed [OUT_W-1:0] data_ff, data_in;
   cell_tag_type            tag_ff;
   logic signed [OUT_W-1:0] delay_ff [DEPTH];
   logic signed [OUT_W-1:0] push, x, tail;
   logic                    fire;

   assign in_ready  = !valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign x         = OUT_W'($signed(in_data[IN_W-1:0]));
   assign tail      = delay_ff[DEPTH-1];
   assign out_valid = valid_ff;
   assign out_data  = LINK_W'(data_ff);
   assign out_tag   = tag_ff;

   // First half of a block parks the input and sends out the stored differences;
   // the second half pairs the parked element with the new one; an inactive cell passes the input through.
   always_comb begin
      if (!ctrl.active) begin
         data_in = x;
         push    = x;
      end else if (phase_ff[STAGE]) begin
         data_in = tail + x;
         push    = tail - x;
      end else begin
         data_in = tail;
         push    = x;
      end
      if (ctrl.clear) begin
         phase_in = PW'(PHASE_INIT);
      end else if (fire) begin
         phase_in = phase_ff + PW'(1);
      end else begin
         phase_in = phase_ff;
      end
      if (fire) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PW'(PHASE_INIT);
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff     <= data_in;
         tag_ff      <= in_tag;
         delay_ff[0] <= push;
         for (int i = 1; i < DEPTH; i++) begin
            delay_ff[i] <= delay_ff[i-1];
         end
      end
   end

endmodule

// ===== rtl/normalized_walsh_hadamard_transform.sv =====
// Top level: streaming orthonormal Walsh-Hadamard transform over a row of cells.
// Throughput: one item per clock while rsp_ready is high; the row of elastic cells sets it.
// Element k of the previous vector is returned with element k of the current one.
// Reset (synchronous, active high) clears counters, pending flag, size and valids.
`include "normalized_walsh_hadamard_transform_macros.svh"
module normalized_walsh_hadamard_transform
   import nwht_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int MAX_LENGTH   = MAX_LENGTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample,
   output logic                           rsp_out_valid,
   output logic                           rsp_out_last,
   output logic                           rsp_saturated,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [CSR_DATA_W-1:0]          csr_pwdata,
   output logic [CSR_DATA_W-1:0]          csr_prdata,
   output logic                           csr_pready
);

   // Number of butterfly cells: floor(log2(MAX_LENGTH)).
   localparam int LG_MAX = $clog2(MAX_LENGTH + 1) - 1;
   localparam int ACC_W  = SAMPLE_WIDTH + LG_MAX;
   localparam int PROD_W = ACC_W + 16;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // Configuration and vector bookkeeping.
   logic [1:0]        size_ff, size_in;
   logic [LG_MAX-1:0] count_ff, count_in;
   logic              pending_ff, pending_in;
   logic              cfg_write;
   logic [1:0]        sel_eff;
   logic [LOG_W-1:0]  lg_raw, lg;
   logic [LG_MAX-1:0] n_minus_1;
   logic              accept;
   cell_tag_type      tag_in;

   // The cell row.
   logic                    link_valid [LG_MAX+1];
   logic                    link_ready [LG_MAX+1];
   logic signed [ACC_W-1:0] link_data  [LG_MAX+1];
   cell_tag_type            link_tag   [LG_MAX+1];
   cell_ctrl_type           cell_ctrl  [LG_MAX];

   // Output stage.
   logic signed [ACC_W-1:0]        hold_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_ovalid_ff, rsp_last_ff, rsp_sat_ff;
   logic                           rsp_sat_in;
   logic                           take;
   logic signed [15:0]             mult_c;
   logic [4:0]                     shamt;
   logic signed [PROD_W-1:0]       prod, scaled;
   logic                           over_hi, over_lo;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1:2] == REG_SIZE_SELECT);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_SIZE_SELECT)
                       ? {{(CSR_DATA_W-2){1'b0}}, size_ff} : '0;

   // Selector three behaves as 512, and the length never exceeds MAX_LENGTH.
   assign sel_eff = (size_ff > SEL_512) ? SEL_512 : size_ff;
   assign lg_raw  = LOG_W'(BASE_LOG) + {2'b00, sel_eff};
   assign lg      = (lg_raw > LOG_W'(LG_MAX)) ? LOG_W'(LG_MAX) : lg_raw;

   always_comb begin
      for (int i = 0; i < LG_MAX; i++) begin
         n_minus_1[i] = (LOG_W'(i) < lg);
      end
   end

   assign accept      = req_valid && req_ready;
   assign tag_in.pend = pending_ff;
   assign tag_in.last = pending_ff && (count_ff == n_minus_1);

   always_comb begin
      size_in    = size_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      if (cfg_write) begin
         size_in    = csr_pwdata[1:0];
         count_in   = '0;
         pending_in = 1'b0;
      end else if (accept) begin
         if (count_ff == n_minus_1) begin
            count_in   = '0;
            pending_in = 1'b1;
         end else begin
            count_in = count_ff + LG_MAX'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         size_ff    <= size_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   // Cell s handles butterflies of span 2**s; spans that reach the vector length
   // are passed straight through.
   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];
   assign link_data[0]  = ACC_W'(req_sample);
   assign link_tag[0]   = tag_in;

   for (genvar s = 0; s < LG_MAX; s++) begin : g_cell
      assign cell_ctrl[s].clear  = cfg_write;
      assign cell_ctrl[s].active = (LOG_W'(s) < lg);

      nwht_cell #(
         .STAGE  (s),
         .IN_W   (SAMPLE_WIDTH + s),
         .LINK_W (ACC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl[s]),
         .in_valid  (link_valid[s]),
         .in_ready  (link_ready[s]),
         .in_data   (link_data[s]),
         .in_tag    (link_tag[s]),
         .out_valid (link_valid[s+1]),
         .out_ready (link_ready[s+1]),
         .out_data  (link_data[s+1]),
         .out_tag   (link_tag[s+1])
      );
   end

   // The row lags the input by one element less than a vector, so the element
   // leaving the row now is one ahead of the one owed; hold_ff keeps the owed one.
   assign take                = link_valid[LG_MAX] && (!rsp_valid_ff || rsp_ready);
   assign link_ready[LG_MAX]  = !rsp_valid_ff || rsp_ready;

   // Scale by 1/sqrt(N): odd log2 lengths use the Q15 constant, even ones a shift.
   always_comb begin
      if (lg[0]) begin
         mult_c = $signed(INV_SQRT2_Q15);
         shamt  = 5'(Q_BITS) + 5'((lg - LOG_W'(1)) >> 1);
      end else begin
         mult_c = 16'sd1;
         shamt  = 5'(lg >> 1);
      end
      prod    = PROD_W'(hold_ff) * PROD_W'(mult_c);
      scaled  = (prod + (PROD_W'(1) <<< (shamt - 5'd1))) >>> shamt;
      over_hi = !scaled[PROD_W-1] && (|scaled[PROD_W-2:SAMPLE_WIDTH-1]);
      over_lo = scaled[PROD_W-1] && !(&scaled[PROD_W-2:SAMPLE_WIDTH-1]);
      if (over_hi) begin
         rsp_sample_in = SAT_MAX;
      end else if (over_lo) begin
         rsp_sample_in = SAT_MIN;
      end else begin
         rsp_sample_in = scaled[SAMPLE_WIDTH-1:0];
      end
      rsp_sat_in = over_hi || over_lo;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Before a vector has completed, the item carries all-zero fields.
   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff       <= link_data[LG_MAX];
         rsp_ovalid_ff <= link_tag[LG_MAX].pend;
         rsp_last_ff   <= link_tag[LG_MAX].last;
         rsp_sample_ff <= link_tag[LG_MAX].pend ? rsp_sample_in : '0;
         rsp_sat_ff    <= link_tag[LG_MAX].pend && rsp_sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_out_valid  = rsp_ovalid_ff;
   assign rsp_out_last   = rsp_last_ff;
   assign rsp_saturated  = rsp_sat_ff;

   `NWHT_ASSERT_IMP(a_last_needs_valid, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_ovalid_ff)
   `NWHT_ASSERT_IMP(a_sat_at_rail, clock, reset, rsp_valid_ff && rsp_sat_ff, rsp_sample_ff == SAT_MAX || rsp_sample_ff == SAT_MIN)
   `NWHT_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, count_ff <= n_minus_1)
   `NWHT_ASSERT_NXT(a_cfg_clears_pending, clock, reset, cfg_write, !pending_ff && count_ff == '0)
   `NWHT_ASSERT_IMP(a_idle_fields_zero, clock, reset, rsp_valid_ff && !rsp_ovalid_ff, rsp_sample_ff == '0 && !rsp_sat_ff)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming normalized Walsh-Hadamard transform.
module testbench
   import nwht_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Pipeline depth of the block for the largest vector, plus margin.
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Input channel.
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample = '0;

   // Result channel.
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_sample;
   logic               rsp_out_valid;
   logic               rsp_out_last;
   logic               rsp_saturated;

   // Register port.
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   normalized_walsh_hadamard_transform i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_last   (rsp_out_last),
      .rsp_saturated  (rsp_saturated),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One expected result item.
   typedef struct {
      logic signed [15:0] value;
      logic               valid;
      logic               last;
      logic               clipped;
   } wht_result_type;

   // Shadow of the block's state, kept by the predictor.
   logic [1:0]         shadow_size;
   logic signed [15:0] vector_in [512];
   logic signed [15:0] vector_out [512];
   logic               vector_clip [512];
   int                 element_index;
   logic               have_vector;

   logic signed [15:0] sample_queue [$];
   wht_result_type     result_queue [$];

   int error_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int vectors_done = 0;
   bit long_hold = 1'b0;

   // Handshakes seen at the rising edge, picked up by the falling-edge drivers.
   bit in_taken = 1'b0;
   bit out_taken = 1'b0;

   // Length as a log2, with selector three treated as 512.
   function automatic int vector_log2(logic [1:0] sel);
      return (sel == 2'd0) ? 7 : (sel == 2'd1) ? 8 : 9;
   endfunction

   // Full Sylvester-order transform of the loaded vector, scaled by 1/sqrt(N),
   // rounded half up and clipped to 16 bits.
   task automatic transform_vector(int lg);
      longint acc [512];
      longint a, b, p, r;
      int n, shift;
      n = 1 << lg;
      for (int i = 0; i < n; i++) acc[i] = vector_in[i];
      for (int h = 1; h < n; h = h * 2)
         for (int i = 0; i < n; i += 2 * h)
            for (int j = i; j < i + h; j++) begin
               a = acc[j];
               b = acc[j + h];
               acc[j] = a + b;
               acc[j + h] = a - b;
            end
      shift = lg[0] ? 15 + (lg - 1) / 2 : lg / 2;
      for (int i = 0; i < n; i++) begin
         p = lg[0] ? acc[i] * 23170 : acc[i];
         // Arithmetic shift of a signed value floors, as needed for round half up.
         r = (p + (64'sd1 <<< (shift - 1))) >>> shift;
         vector_clip[i] = 1'b0;
         if (r > 32767) begin
            r = 32767;
            vector_clip[i] = 1'b1;
         end
         if (r < -32768) begin
            r = -32768;
            vector_clip[i] = 1'b1;
         end
         vector_out[i] = r[15:0];
      end
   endtask

   // Expected result for one accepted sample; updates the shadow state.
   task automatic predict_sample(logic signed [15:0] s);
      wht_result_type e;
      int lg, n;
      lg = vector_log2(shadow_size);
      n = 1 << lg;
      if (have_vector) begin
         e.value = vector_out[element_index];
         e.valid = 1'b1;
         e.last = (element_index == n - 1);
         e.clipped = vector_clip[element_index];
      end else begin
         e = '{16'sd0, 1'b0, 1'b0, 1'b0};
      end
      result_queue.push_back(e);
      vector_in[element_index] = s;
      element_index++;
      if (element_index >= n) begin
         transform_vector(lg);
         have_vector = 1'b1;
         element_index = 0;
         vectors_done++;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      error_count++;
   endtask

   // Input acceptance is taken at the rising edge, where the handshake counts.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_sample(req_sample);
         items_sent++;
         in_taken = 1'b1;
      end
   end

   // Driver: takes samples from the queue, with a random gap before each one.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset && !(req_valid && !in_taken)) begin
         if (in_taken) begin
            in_taken = 1'b0;
            send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_sample <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks every accepted result against the oldest expectation.
   always @(posedge clock) begin
      wht_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         out_taken = 1'b1;
         if (result_queue.size() == 0) begin
            $display("unexpected result item %0d", results_seen);
            error_count++;
         end else begin
            e = result_queue.pop_front();
            if (rsp_out_valid !== e.valid)
               report_mismatch("out_valid", rsp_out_valid, e.valid);
            if (rsp_out_sample !== e.value)
               report_mismatch("out_sample", rsp_out_sample, e.value);
            if (rsp_out_last !== e.last)
               report_mismatch("out_last", rsp_out_last, e.last);
            if (rsp_saturated !== e.clipped)
               report_mismatch("saturated", rsp_saturated, e.clipped);
         end
      end
   end

   // Receiver stall: random per item, or a long hold-off that fills the block.
   int recv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (out_taken) begin
            out_taken = 1'b0;
            recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_ready <= !long_hold && (recv_gap == 0);
      end
   end

   // Register write: setup then access phase, changed at the falling edge.
   task automatic write_size(logic [1:0] sel);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * REG_SIZE_SELECT);
      csr_pwdata <= {30'd0, sel};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      shadow_size = sel;
      element_index = 0;
      have_vector = 1'b0;
   endtask

   // Waits until every queued sample went in and every result came out.
   task automatic wait_drained();
      while (sample_queue.size() > 0 || req_valid || result_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly uniform random values, with some small ones and some full-scale ones so that sums clip.
   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return $signed(16'($urandom_range(0, 255)) - 16'd128);
         default: return $signed(16'($urandom()));
      endcase
   endfunction

   initial begin
      logic [1:0] sizes [4];
      int count;
      int extra;
      shadow_size = 2'd0;
      element_index = 0;
      have_vector = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes and a partial vector, in the reset size of 128.
      sample_queue.push_back(16'sh7fff);
      sample_queue.push_back(16'sh8000);
      sample_queue.push_back(16'sh0000);
      sample_queue.push_back(16'shffff);
      sample_queue.push_back(16'sh0001);
      wait_drained();
      // A write mid-vector drops the partial vector and any pending results.
      write_size(2'd1);
      wait_drained();

      // Each size in turn, the extremes and selector three among them.
      sizes = '{2'd0, 2'd2, 2'd1, 2'd3};
      foreach (sizes[s]) begin
         write_size(sizes[s]);
         if (s == 0) begin
            // All full scale: the DC bin clips.
            for (int i = 0; i < 128; i++) sample_queue.push_back(16'sh7fff);
            for (int i = 0; i < 128; i++) sample_queue.push_back(16'sh8000);
         end else begin
            // Selector three gets more than 256 samples but less than a vector,
            // so any shorter length would show up as early results.
            count = (s == 3) ? 260 : (1 << vector_log2(sizes[s]));
            for (int i = 0; i < count; i++) sample_queue.push_back(random_sample());
         end
         if (s == 1) begin
            // Hold the receiver while samples keep coming, so the block stalls.
            long_hold = 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         // A trailing partial vector, dropped by the next write.
         extra = $urandom_range(1, 40);
         for (int i = 0; i < extra; i++)
            sample_queue.push_back(random_sample());
         wait_drained();
      end

      $display("run covered %0d samples, %0d results, %0d completed vectors",
               items_sent, results_seen, vectors_done);
      $display("sizes 128, 256, 512 and selector three, with mid-vector writes");
      if (error_count == 0 && result_queue.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
